### hdl/pch_pkg.sv
package pch_pkg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_SWEEP,
        S_TAIL
    } t_state;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_ERROR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] KIND_DONE   = 2'd0;
    localparam logic [1:0] KIND_FAILED = 2'd1;
    localparam logic [1:0] KIND_BIN    = 2'd2;

    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;
    localparam logic [3:0] HEADER_BYTES    = 4'd8;

endpackage

### hdl/pch_ram.sv
module pch_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 95
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/printable_char_histogram.sv
// every result is registered and appears in the cycle after its item is accepted, strobed by o_valid
// one item per cycle while busy is low; the connection bin memory
//   is read one cycle and written the next, with the write forwarded to a following byte
// connection end (with payload) or link error: busy through S_SWEEP and S_TAIL, one bin per
//   cycle swept through both memories; after reset busy in S_CLEAR to zero them
// reset is synchronous and active low; results cannot be stalled by the receiver
module printable_char_histogram
    import pch_pkg::*;
#(
    parameter int NUM_BINS = 95
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_byte_value,
    input  logic [6:0]  i_bin_index,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [63:0] o_count
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_commit, n_commit;
    logic [63:0]     r_len, n_len;
    logic [3:0]      r_hdr, n_hdr;
    logic [63:0]     r_remain, n_remain;
    logic [63:0]     r_pcount, n_pcount;
    logic            r_p_valid, n_p_valid;
    logic [AW-1:0]   r_p_idx, n_p_idx;
    logic            r_sw_valid, n_sw_valid;
    logic [AW-1:0]   r_sw_idx, n_sw_idx;
    logic            r_fw_valid;
    logic [AW-1:0]   r_fw_idx;
    logic [63:0]     r_fw_data;
    logic            r_res_valid, n_res_valid;
    logic [1:0]      r_res_kind, n_res_kind;
    logic [63:0]     r_res_count, n_res_count;
    logic            r_res_mem, n_res_mem;

    logic            conn_we, tot_we;
    logic [AW-1:0]   conn_waddr, conn_raddr, tot_waddr, tot_raddr;
    logic [63:0]     conn_wdata, tot_wdata, conn_rd, tot_rd;
    logic [63:0]     p_cur, sw_cur, new_len;
    logic            accept, printable, pay_last;

    assign busy      = (r_state != S_RUN);
    assign accept    = start && !busy;
    assign printable = i_byte_value inside {[FIRST_PRINTABLE:LAST_PRINTABLE]};
    assign pay_last  = (r_hdr == HEADER_BYTES) && (r_remain == 64'd1);
    assign new_len   = {r_len[55:0], i_byte_value};

    // a write to the same bin in the cycle of the read is not yet in the read data
    assign p_cur  = (r_fw_valid && r_fw_idx == r_p_idx)  ? r_fw_data : conn_rd;
    assign sw_cur = (r_fw_valid && r_fw_idx == r_sw_idx) ? r_fw_data : conn_rd;

    pch_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_conn_ram (
        .i_clk   (i_clk),
        .i_we    (conn_we),
        .i_waddr (conn_waddr),
        .i_wdata (conn_wdata),
        .i_raddr (conn_raddr),
        .o_rdata (conn_rd)
    );

    pch_ram #(.WIDTH(64), .DEPTH(NUM_BINS)) u_total_ram (
        .i_clk   (i_clk),
        .i_we    (tot_we),
        .i_waddr (tot_waddr),
        .i_wdata (tot_wdata),
        .i_raddr (tot_raddr),
        .o_rdata (tot_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == LAST_BIN) n_state = S_RUN;
            end
            S_RUN: begin
                if (accept && (i_op == OP_ERROR || (i_op == OP_BYTE && pay_last))) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (r_cnt == LAST_BIN) n_state = S_TAIL;
            end
            S_TAIL: begin
                n_state = S_RUN;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_commit    = r_commit;
        n_len       = r_len;
        n_hdr       = r_hdr;
        n_remain    = r_remain;
        n_pcount    = r_pcount;
        n_p_valid   = 1'b0;
        n_p_idx     = r_p_idx;
        n_sw_valid  = 1'b0;
        n_sw_idx    = r_sw_idx;
        n_res_valid = 1'b0;
        n_res_kind  = r_res_kind;
        n_res_count = r_res_count;
        n_res_mem   = 1'b0;

        conn_we    = r_p_valid;
        conn_waddr = r_p_idx;
        conn_wdata = p_cur + 64'd1;
        conn_raddr = AW'(i_byte_value - FIRST_PRINTABLE);
        tot_we     = 1'b0;
        tot_waddr  = r_sw_idx;
        tot_wdata  = tot_rd + sw_cur;
        tot_raddr  = AW'(i_bin_index);

        // sweep write stage: clear the connection bin, fold it into the total on commit
        if (r_sw_valid) begin
            conn_we    = 1'b1;
            conn_waddr = r_sw_idx;
            conn_wdata = '0;
            tot_we     = r_commit;
        end

        case (r_state)
            S_CLEAR: begin
                conn_we    = 1'b1;
                conn_waddr = r_cnt;
                conn_wdata = '0;
                tot_we     = 1'b1;
                tot_waddr  = r_cnt;
                tot_wdata  = '0;
                n_cnt      = (r_cnt == LAST_BIN) ? '0 : r_cnt + AW'(1);
            end
            S_SWEEP: begin
                conn_raddr = r_cnt;
                tot_raddr  = r_cnt;
                n_sw_valid = 1'b1;
                n_sw_idx   = r_cnt;
                n_cnt      = (r_cnt == LAST_BIN) ? '0 : r_cnt + AW'(1);
            end
            S_RUN: begin
                if (accept) begin
                    case (i_op)
                        OP_BYTE: begin
                            if (r_hdr != HEADER_BYTES) begin
                                n_len = new_len;
                                n_hdr = r_hdr + 4'd1;
                                if (r_hdr == HEADER_BYTES - 4'd1) begin
                                    n_remain = new_len;
                                    // zero length ends the connection with nothing to fold
                                    if (new_len == 64'd0) begin
                                        n_len       = '0;
                                        n_hdr       = '0;
                                        n_res_valid = 1'b1;
                                        n_res_kind  = KIND_DONE;
                                        n_res_count = '0;
                                    end
                                end
                            end else begin
                                n_p_valid = printable;
                                n_p_idx   = AW'(i_byte_value - FIRST_PRINTABLE);
                                n_pcount  = r_pcount + {63'd0, printable};
                                n_remain  = r_remain - 64'd1;
                                if (pay_last) begin
                                    n_res_valid = 1'b1;
                                    n_res_kind  = KIND_DONE;
                                    n_res_count = r_pcount + {63'd0, printable};
                                    n_len       = '0;
                                    n_hdr       = '0;
                                    n_remain    = '0;
                                    n_pcount    = '0;
                                    n_commit    = 1'b1;
                                    n_cnt       = '0;
                                end
                            end
                        end
                        OP_ERROR: begin
                            n_res_valid = 1'b1;
                            n_res_kind  = KIND_FAILED;
                            n_res_count = '0;
                            n_len       = '0;
                            n_hdr       = '0;
                            n_remain    = '0;
                            n_pcount    = '0;
                            n_commit    = 1'b0;
                            n_cnt       = '0;
                        end
                        OP_QUERY: begin
                            n_res_valid = 1'b1;
                            n_res_kind  = KIND_BIN;
                            n_res_count = '0;
                            n_res_mem   = (i_bin_index < NUM_BINS);
                        end
                        default: ;
                    endcase
                end
            end
            S_TAIL: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_commit    <= 1'b0;
            r_len       <= '0;
            r_hdr       <= '0;
            r_remain    <= '0;
            r_pcount    <= '0;
            r_p_valid   <= 1'b0;
            r_sw_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_mem   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_commit    <= n_commit;
            r_len       <= n_len;
            r_hdr       <= n_hdr;
            r_remain    <= n_remain;
            r_pcount    <= n_pcount;
            r_p_valid   <= n_p_valid;
            r_sw_valid  <= n_sw_valid;
            r_fw_valid  <= conn_we;
            r_res_valid <= n_res_valid;
            r_res_mem   <= n_res_mem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx     <= n_p_idx;
        r_sw_idx    <= n_sw_idx;
        r_fw_idx    <= conn_waddr;
        r_fw_data   <= conn_wdata;
        r_res_kind  <= n_res_kind;
        r_res_count <= n_res_count;
    end

    assign o_valid = r_res_valid;
    assign o_kind  = r_res_kind;
    assign o_count = r_res_mem ? tot_rd : r_res_count;

endmodule

### hdl/pch_check.sv
module pch_check
    import pch_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_op,
    input logic [7:0]  i_byte_value,
    input logic [6:0]  i_bin_index,
    input logic        o_valid,
    input logic [1:0]  o_kind,
    input logic [63:0] o_count
);

    logic accept;
    assign accept = start && !busy;

    // every result follows an accepted item in the next cycle
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept))
        else $error("result without an accepted item");

    // a link error reports failure with a zero count
    a_error_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_ERROR |=> o_valid && o_kind == KIND_FAILED && o_count == 64'd0)
        else $error("link error not reported as failed");

    // a link error starts the bin sweep
    a_error_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_ERROR |=> busy)
        else $error("no sweep after link error");

    // a query always answers with a bin value
    a_query_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_QUERY |=> o_valid && o_kind == KIND_BIN)
        else $error("query not answered");

    // an out of range bin reads as zero
    a_query_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_op == OP_QUERY && i_bin_index > 7'd94 |=> o_count == 64'd0)
        else $error("out of range bin not zero");

endmodule

bind printable_char_histogram pch_check u_pch_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_op         (i_op),
    .i_byte_value (i_byte_value),
    .i_bin_index  (i_bin_index),
    .o_valid      (o_valid),
    .o_kind       (o_kind),
    .o_count      (o_count)
);

### sim/printable_char_histogram_test.sv
module printable_char_histogram_test;
    import pch_pkg::*;

    localparam int NUM_BINS = 95;
    localparam int STALL_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_RESULT,
        CHK_NONE
    } t_check;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] count;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  value;
        logic [6:0]  bin;
        t_check      check;
        logic [1:0]  kind;
        logic [63:0] count;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [7:0]  i_byte_value;
    logic [6:0]  i_bin_index;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [63:0] o_count;

    // typed-in expectation that travels with the item on the ports
    t_check      typed_mode;
    logic [1:0]  typed_kind;
    logic [63:0] typed_count;

    // predictor state
    logic [63:0] total_hist [NUM_BINS];
    logic [63:0] conn_hist [NUM_BINS];
    logic [63:0] hdr_shift;
    logic [3:0]  hdr_seen;
    logic [63:0] bytes_left;
    logic [63:0] conn_printable;

    t_result     pending_results [$];
    t_result     want;
    t_result     predicted;
    bit          got_result;
    bit          took_item;
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          idle_pct = 0;

    t_stim_row directed_rows [0:24] = '{
        '{OP_QUERY,  8'h00, 7'd127, CHK_RESULT, KIND_BIN,    64'd0},
        '{OP_ERROR,  8'h00, 7'd0,   CHK_RESULT, KIND_FAILED, 64'd0},
        '{OP_UNUSED, 8'hff, 7'd127, CHK_NONE,   KIND_DONE,   64'd0},
        // zero length header
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_RESULT, KIND_DONE,   64'd0},
        // three byte payload with both printable extremes
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'h03, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'd126, 7'd0,  CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'd31, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_BYTE,   8'd32, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_QUERY,  8'h00, 7'd94,  CHK_MODEL,  KIND_DONE,   64'd0},
        // error in the middle of a header
        '{OP_BYTE,   8'h00, 7'd0,   CHK_MODEL,  KIND_DONE,   64'd0},
        '{OP_ERROR,  8'h00, 7'd0,   CHK_RESULT, KIND_FAILED, 64'd0}
    };

    printable_char_histogram #(
        .NUM_BINS(NUM_BINS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_byte_value(i_byte_value),
        .i_bin_index(i_bin_index),
        .o_valid(o_valid),
        .o_kind(o_kind),
        .o_count(o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic clear_connection();
        for (int k = 0; k < NUM_BINS; k++) conn_hist[k] = 64'd0;
        hdr_shift = 64'd0;
        hdr_seen = 4'd0;
        bytes_left = 64'd0;
        conn_printable = 64'd0;
    endtask

    task automatic commit_connection(output t_result r);
        for (int k = 0; k < NUM_BINS; k++) total_hist[k] = total_hist[k] + conn_hist[k];
        r.kind = KIND_DONE;
        r.count = conn_printable;
        clear_connection();
    endtask

    task automatic histogram_step(input logic [1:0] op, input logic [7:0] value,
                                  input logic [6:0] bin, output bit has, output t_result r);
        logic [6:0] idx;
        has = 1'b0;
        r.kind = KIND_DONE;
        r.count = 64'd0;
        case (op)
            OP_BYTE: begin
                if (hdr_seen < HEADER_BYTES) begin
                    hdr_shift = {hdr_shift[55:0], value};
                    hdr_seen = hdr_seen + 4'd1;
                    if (hdr_seen == HEADER_BYTES) begin
                        bytes_left = hdr_shift;
                        if (bytes_left == 64'd0) begin
                            commit_connection(r);
                            has = 1'b1;
                        end
                    end
                end else begin
                    if (value >= FIRST_PRINTABLE && value <= LAST_PRINTABLE) begin
                        idx = 7'(value - FIRST_PRINTABLE);
                        conn_hist[idx] = conn_hist[idx] + 64'd1;
                        conn_printable = conn_printable + 64'd1;
                    end
                    if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
                    if (bytes_left == 64'd0) begin
                        commit_connection(r);
                        has = 1'b1;
                    end
                end
            end
            OP_ERROR: begin
                clear_connection();
                r.kind = KIND_FAILED;
                has = 1'b1;
            end
            OP_QUERY: begin
                r.kind = KIND_BIN;
                r.count = (bin < NUM_BINS) ? total_hist[bin] : 64'd0;
                has = 1'b1;
            end
            default: begin
            end
        endcase
    endtask

    // results are compared first, then the item taken at this edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BINS; k++) total_hist[k] = 64'd0;
            clear_connection();
            stall_cycles = 0;
        end else begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d count %0d",
                             $time, o_kind, o_count);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, o_kind);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, want.count, o_count);
                        fail_count++;
                    end
                end
            end
            took_item = (start === 1'b1) && (busy === 1'b0);
            if (took_item) begin
                histogram_step(i_op, i_byte_value, i_bin_index, got_result, predicted);
                if (typed_mode == CHK_RESULT) begin
                    predicted.kind = typed_kind;
                    predicted.count = typed_count;
                    pending_results.push_back(predicted);
                end else if (typed_mode == CHK_MODEL && got_result) begin
                    pending_results.push_back(predicted);
                end
            end
            stall_cycles = (took_item || o_valid === 1'b1) ? 0 : stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] value, input logic [6:0] bin,
                             input t_check mode, input logic [1:0] kind, input logic [63:0] cnt);
        i_op <= op;
        i_byte_value <= value;
        i_bin_index <= bin;
        typed_mode <= mode;
        typed_kind <= kind;
        typed_count <= cnt;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // each following cycle stays idle with the given chance
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic run_traffic(input int n_items, input int gap_pct);
        int          sent;
        int          sel;
        int          abort_at;
        int          span;
        logic [63:0] len;
        logic [7:0]  value;
        logic [6:0]  qbin;
        sent = 0;
        idle_pct = gap_pct;
        while (sent < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                // well-formed connection, now and then cut short by a link error
                sel = $urandom_range(0, 99);
                if (sel < 80) len = 64'($urandom_range(0, 12));
                else if (sel < 95) len = 64'($urandom_range(13, 60));
                else len = 64'($urandom_range(61, 250));
                span = 8 + int'(len);
                abort_at = ($urandom_range(0, 99) < 6) ? int'($urandom_range(0, span - 1)) : -1;
                for (int i = 0; i < span; i++) begin
                    if (i == abort_at) begin
                        send_item(OP_ERROR, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)), CHK_MODEL, KIND_DONE, 64'd0);
                        sent++;
                        break;
                    end
                    if ($urandom_range(0, 99) < 3) begin
                        if ($urandom_range(0, 1) == 0) begin
                            send_item(OP_QUERY, 8'($urandom_range(0, 255)),
                                      7'($urandom_range(0, 127)), CHK_MODEL, KIND_DONE, 64'd0);
                            sent++;
                        end else begin
                            send_item(OP_UNUSED, 8'($urandom_range(0, 255)),
                                      7'($urandom_range(0, 127)), CHK_MODEL, KIND_DONE, 64'd0);
                        end
                    end
                    if (i < 8) value = len[63 - 8 * i -: 8];
                    else if ($urandom_range(0, 99) < 75) value = 8'($urandom_range(32, 126));
                    else value = 8'($urandom_range(0, 255));
                    send_item(OP_BYTE, value, 7'($urandom_range(0, 127)),
                              CHK_MODEL, KIND_DONE, 64'd0);
                    sent++;
                end
            end else if (sel < 85) begin
                // mostly bins in range, some past the end
                if ($urandom_range(0, 99) < 85) qbin = 7'($urandom_range(0, 94));
                else qbin = 7'($urandom_range(95, 127));
                send_item(OP_QUERY, 8'($urandom_range(0, 255)), qbin,
                          CHK_MODEL, KIND_DONE, 64'd0);
                sent++;
            end else if (sel < 92) begin
                send_item(OP_ERROR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          CHK_MODEL, KIND_DONE, 64'd0);
                sent++;
            end else if (sel < 96) begin
                send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          CHK_MODEL, KIND_DONE, 64'd0);
            end else begin
                // broken connection: random header bytes, a few payload bytes, then an error
                span = int'($urandom_range(1, 8)) + int'($urandom_range(0, 5));
                for (int i = 0; i < span; i++) begin
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                              CHK_MODEL, KIND_DONE, 64'd0);
                    sent++;
                end
                send_item(OP_ERROR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          CHK_MODEL, KIND_DONE, 64'd0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_op <= OP_BYTE;
        i_byte_value <= 8'd0;
        i_bin_index <= 7'd0;
        typed_mode <= CHK_MODEL;
        typed_kind <= KIND_DONE;
        typed_count <= 64'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_item(directed_rows[n].op, directed_rows[n].value, directed_rows[n].bin,
                      directed_rows[n].check, directed_rows[n].kind, directed_rows[n].count);
        end

        run_traffic(440, 0);
        run_traffic(440, 65);
        run_traffic(440, 0);
        run_traffic(440, 31);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NUM_BINS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
